FILE: design/n2f_pkg.sv
// shared types, register codes and ratio tables for the note to frequency converter
package n2f_pkg;

	localparam int NOTE_W      = 7;
	localparam int FREQ_W      = 24;
	localparam int REF_W       = 18;
	localparam int SCALE_W     = 4;
	localparam int CFG_DATA_W  = 18;
	localparam int CFG_IDX_W   = 1;
	localparam int RATIO_FRAC  = 20;
	localparam int RATIO_W     = RATIO_FRAC + 1;
	localparam int OCT_W       = 4;
	localparam int PC_W        = 4;
	localparam int SOLF_W      = 10;
	localparam int PROD_W      = REF_W + RATIO_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int ROUND_BASE  = RATIO_FRAC + 5;
	localparam int SOLF_DROP   = 5;

	localparam int NOTE_COUNT_DEF = 128;
	localparam int FRAC_BITS_DEF  = 8;

	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TUNING_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_A  = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd3;
	localparam logic [REF_W-1:0]   REF_RST   = 18'd112640;

	// scale codes
	localparam logic [SCALE_W-1:0] SCALE_DIA0   = 4'd0;
	localparam logic [SCALE_W-1:0] SCALE_DIA1   = 4'd1;
	localparam logic [SCALE_W-1:0] SCALE_DIA2   = 4'd2;
	localparam logic [SCALE_W-1:0] SCALE_EQUAL  = 4'd3;
	localparam logic [SCALE_W-1:0] SCALE_PYTH   = 4'd4;
	localparam logic [SCALE_W-1:0] SCALE_JUST   = 4'd5;
	localparam logic [SCALE_W-1:0] SCALE_ENHARM = 4'd6;
	localparam logic [SCALE_W-1:0] SCALE_HARM   = 4'd7;
	localparam logic [SCALE_W-1:0] SCALE_SOLF   = 4'd8;

	// pitch class membership, bit pc set if present
	localparam logic [11:0] DIATONIC_MASK  = 12'hAB5;
	localparam logic [11:0] SOLFEGGIO_MASK = 12'h2B5;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_PYTH,
		MODE_EQUAL,
		MODE_JUST,
		MODE_ZERO,
		MODE_SOLF
	} mode_t;

	// ratio to A of the same octave, 20 fraction bits, one integer bit
	function automatic logic [RATIO_W-1:0] ratio_rom(input mode_t mode, input logic [PC_W-1:0] pc);
		logic [RATIO_W-1:0] r;
		r = '0;
		case (mode)
			MODE_PYTH: begin
				case (pc)
					4'd0:  r = 21'd621378;
					4'd1:  r = 21'd663552;
					4'd2:  r = 21'd699051;
					4'd3:  r = 21'd746496;
					4'd4:  r = 21'd786432;
					4'd5:  r = 21'd828504;
					4'd6:  r = 21'd884736;
					4'd7:  r = 21'd932068;
					4'd8:  r = 21'd995328;
					4'd9:  r = 21'd1048576;
					4'd10: r = 21'd1119744;
					4'd11: r = 21'd1179648;
					default: r = '0;
				endcase
			end
			MODE_EQUAL: begin
				case (pc)
					4'd0:  r = 21'd623487;
					4'd1:  r = 21'd660561;
					4'd2:  r = 21'd699841;
					4'd3:  r = 21'd741455;
					4'd4:  r = 21'd785544;
					4'd5:  r = 21'd832255;
					4'd6:  r = 21'd881744;
					4'd7:  r = 21'd934175;
					4'd8:  r = 21'd989724;
					4'd9:  r = 21'd1048576;
					4'd10: r = 21'd1110928;
					4'd11: r = 21'd1176987;
					default: r = '0;
				endcase
			end
			MODE_JUST: begin
				case (pc)
					4'd0:  r = 21'd629146;
					4'd1:  r = 21'd655360;
					4'd2:  r = 21'd707789;
					4'd3:  r = 21'd737280;
					4'd4:  r = 21'd786432;
					4'd5:  r = 21'd838861;
					4'd6:  r = 21'd873813;
					4'd7:  r = 21'd943718;
					4'd8:  r = 21'd983040;
					4'd9:  r = 21'd1048576;
					4'd10: r = 21'd1092267;
					4'd11: r = 21'd1179648;
					default: r = '0;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// absolute solfeggio frequencies in hz, shifted up by FRAC_BITS plus octave and divided by 32 downstream
	function automatic logic [SOLF_W-1:0] solf_rom(input logic [PC_W-1:0] pc);
		logic [SOLF_W-1:0] f;
		case (pc)
			4'd0:    f = 10'd396;
			4'd2:    f = 10'd417;
			4'd4:    f = 10'd528;
			4'd5:    f = 10'd639;
			4'd7:    f = 10'd741;
			4'd9:    f = 10'd852;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

FILE: design/note_to_frequency_tuning_top.sv
// note number to frequency converter, four stage pipeline
// The block turns a 7-bit note number into a 24-bit frequency in units of
// 2^-FRAC_BITS Hz plus an availability flag, under the tuning scale and the
// reference A (note 69) frequency held in two configuration registers. It
// takes one item per clock while the output is not stalled: stage 1
// splits the note into octave and pitch class and decodes the scale, stage 2
// reads the ratio table, stage 3 holds the 18x21 multiply (the longest path),
// and stage 4 rounds, shifts by the octave and saturates into the output
// register. All stages move together, so a stall at the output holds the
// whole pipeline and nothing is dropped or repeated. Notes outside the scale
// give zero and are flagged unavailable; the harmonic scale gives zero with
// the flag set; solfeggio uses fixed absolute pitches and ignores reference A.
// Configuration is meant to change only while the pipeline is empty.
module note_to_frequency_tuning_top
	import n2f_pkg::*;
#(
	parameter int NOTE_COUNT = NOTE_COUNT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input item channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [NOTE_W-1:0]     note_number,
	// result item channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FREQ_W-1:0]     frequency,
	output logic                  note_available
);

	// configuration registers
	logic [SCALE_W-1:0] tuning_scale_q;
	logic [REF_W-1:0]   reference_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_scale_q <= SCALE_RST;
			reference_a_q  <= REF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TUNING_SCALE: tuning_scale_q <= cfg_data[SCALE_W-1:0];
				REG_REFERENCE_A:  reference_a_q  <= cfg_data[REF_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output register holds an item that is stalled
	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// stage 1: octave, pitch class and scale decode
	logic [12:0]       oct_prod;
	logic [OCT_W-1:0]  oct_c;
	logic [NOTE_W-1:0] oct_base;
	logic [PC_W-1:0]   pc_c;
	logic              in_range;
	mode_t             mode_c;

	// note / 12 as (note * 43) >> 9, exact for 7-bit notes
	assign oct_prod = 13'(note_number) * 13'd43;
	assign oct_c    = oct_prod[12:9];
	assign oct_base = 7'(oct_c) * 7'd12;
	assign pc_c     = PC_W'(note_number - oct_base);
	assign in_range = ({1'b0, note_number} < 8'(NOTE_COUNT));

	always_comb begin
		mode_c = MODE_NONE;
		if (in_range) begin
			case (tuning_scale_q)
				SCALE_DIA0, SCALE_DIA1, SCALE_DIA2: begin
					if (DIATONIC_MASK[pc_c]) begin
						mode_c = MODE_PYTH;
					end
				end
				SCALE_EQUAL:               mode_c = MODE_EQUAL;
				SCALE_PYTH, SCALE_ENHARM: mode_c = MODE_PYTH;
				SCALE_JUST:                mode_c = MODE_JUST;
				SCALE_HARM:                mode_c = MODE_ZERO;
				SCALE_SOLF: begin
					if (SOLFEGGIO_MASK[pc_c]) begin
						mode_c = MODE_SOLF;
					end
				end
				default:                   mode_c = MODE_NONE;
			endcase
		end
	end

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [PC_W-1:0]  pc_s1;
	logic [OCT_W-1:0] oct_s1, oct_s2, oct_s3;
	mode_t            mode_s1, mode_s2, mode_s3;

	// stage 2 payload
	logic [RATIO_W-1:0] ratio_s2;
	logic [SOLF_W-1:0]  solf_s2;

	// stage 3 payload
	logic [PROD_W-1:0] prod_s3;
	logic [SUM_W-1:0]  solf_s3;

	// stage 4 payload, the output register
	logic [FREQ_W-1:0] freq_s4;
	logic              avail_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pc_s1   <= pc_c;
			oct_s1  <= oct_c;
			mode_s1 <= mode_c;
		end
	end

	// stage 2: ratio and solfeggio table reads
	always_ff @(posedge clk) begin
		if (advance) begin
			ratio_s2 <= ratio_rom(mode_s1, pc_s1);
			solf_s2  <= solf_rom(pc_s1);
			oct_s2   <= oct_s1;
			mode_s2  <= mode_s1;
		end
	end

	// stage 3: reference times ratio, solfeggio pitch scaled up by octave
	logic [5:0] solf_sh;
	assign solf_sh = 6'(FRAC_BITS) + 6'(oct_s2);

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3 <= PROD_W'(reference_a_q) * PROD_W'(ratio_s2);
			solf_s3 <= SUM_W'(solf_s2) << solf_sh;
			oct_s3  <= oct_s2;
			mode_s3 <= mode_s2;
		end
	end

	// stage 4: round half up, shift by octave distance, saturate
	logic [4:0]        rnd_sh;
	logic [SUM_W-1:0]  rat_sum, rat_shr, solf_sum, solf_shr;
	logic [FREQ_W-1:0] rat_freq, solf_freq, freq_c;

	assign rnd_sh    = 5'(ROUND_BASE) - 5'(oct_s3);
	assign rat_sum   = SUM_W'(prod_s3) + (SUM_W'(1) << (rnd_sh - 5'd1));
	assign rat_shr   = rat_sum >> rnd_sh;
	assign rat_freq  = (|rat_shr[SUM_W-1:FREQ_W]) ? FREQ_MAX : rat_shr[FREQ_W-1:0];
	assign solf_sum  = solf_s3 + SUM_W'(16);
	assign solf_shr  = solf_sum >> SOLF_DROP;
	assign solf_freq = (|solf_shr[SUM_W-1:FREQ_W]) ? FREQ_MAX : solf_shr[FREQ_W-1:0];

	always_comb begin
		case (mode_s3)
			MODE_PYTH, MODE_EQUAL, MODE_JUST: freq_c = rat_freq;
			MODE_SOLF:                        freq_c = solf_freq;
			default:                          freq_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			freq_s4  <= freq_c;
			avail_s4 <= (mode_s3 != MODE_NONE);
		end
	end

	assign out_valid      = valid_s4;
	assign frequency      = freq_s4;
	assign note_available = avail_s4;

	// an unavailable note never carries a frequency
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !note_available) |-> (frequency == '0))
		else $error("unavailable note with nonzero frequency");

	// an accepted item always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost at stage 1");

	// stage 3 keeps its item while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !advance) |=> (valid_s3 && $stable(prod_s3) && $stable(mode_s3)))
		else $error("stage 3 changed while stalled");

endmodule
